// ----- rtl/core/rhh_pkg.sv -----
// ----------------------------------------------------------------------------
// rhh_pkg: shared types and constants for the RGB to HSV/HSL converter
// Holds the color width, hue scale, result widths and the hue sector enum.
// ----------------------------------------------------------------------------
package rhh_pkg;

  localparam int unsigned ColorBitsDef = 8;
  localparam int unsigned HueUnit      = 3840;  // 64 * 60
  localparam int unsigned HueW         = 15;
  localparam int unsigned SatW         = 17;

  typedef enum logic [1:0] {
    SECT_RED_POS = 2'd0,
    SECT_RED_NEG = 2'd1,
    SECT_GREEN   = 2'd2,
    SECT_BLUE    = 2'd3
  } sector_e;

endpackage

// ----- rtl/core/rhh_div_cell.sv -----
// ----------------------------------------------------------------------------
// rhh_div_cell: one restoring-division step for three quotients at once
// Each cell produces one quotient bit of hue, hsv and hsl saturation.
// ----------------------------------------------------------------------------
module rhh_div_cell import rhh_pkg::*; #(
  parameter int unsigned CB = ColorBitsDef,
  parameter int unsigned NumW = 24,
  parameter int unsigned QW = 17,
  parameter int unsigned Shift = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [NumW-1:0]   hn_i,
  input  logic [CB-1:0]     hd_i,
  input  logic [QW-1:0]     hq_i,
  input  logic [NumW-1:0]   vn_i,
  input  logic [CB-1:0]     vd_i,
  input  logic [QW-1:0]     vq_i,
  input  logic [NumW-1:0]   ln_i,
  input  logic [CB-1:0]     ld_i,
  input  logic [QW-1:0]     lq_i,
  input  logic [CB-1:0]     mx_i,
  input  logic [CB:0]       sum_i,
  input  logic              ok_i,
  output logic              vld_o,
  output logic [NumW-1:0]   hn_o,
  output logic [CB-1:0]     hd_o,
  output logic [QW-1:0]     hq_o,
  output logic [NumW-1:0]   vn_o,
  output logic [CB-1:0]     vd_o,
  output logic [QW-1:0]     vq_o,
  output logic [NumW-1:0]   ln_o,
  output logic [CB-1:0]     ld_o,
  output logic [QW-1:0]     lq_o,
  output logic [CB-1:0]     mx_o,
  output logic [CB:0]       sum_o,
  output logic              ok_o
);

  logic [NumW-1:0] hs_w, vs_w, ls_w;
  logic hb, vb, lb;
  logic [NumW-1:0] hn_d, vn_d, ln_d;

  assign hs_w = NumW'(hd_i) << Shift;
  assign vs_w = NumW'(vd_i) << Shift;
  assign ls_w = NumW'(ld_i) << Shift;
  // shifted divisor must not lose bits: compare with full-width guard
  assign hb = ((NumW+CB)'(hn_i) >= ((NumW+CB)'(hd_i) << Shift));
  assign vb = ((NumW+CB)'(vn_i) >= ((NumW+CB)'(vd_i) << Shift));
  assign lb = ((NumW+CB)'(ln_i) >= ((NumW+CB)'(ld_i) << Shift));
  assign hn_d = hb ? hn_i - hs_w : hn_i;
  assign vn_d = vb ? vn_i - vs_w : vn_i;
  assign ln_d = lb ? ln_i - ls_w : ln_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hn_o  <= hn_d;
    vn_o  <= vn_d;
    ln_o  <= ln_d;
    hd_o  <= hd_i;
    vd_o  <= vd_i;
    ld_o  <= ld_i;
    hq_o  <= hq_i | (QW'(hb) << Shift);
    vq_o  <= vq_i | (QW'(vb) << Shift);
    lq_o  <= lq_i | (QW'(lb) << Shift);
    mx_o  <= mx_i;
    sum_o <= sum_i;
    ok_o  <= ok_i;
  end

endmodule

// ----- rtl/core/rgb_to_hsv_hsl_core.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_hsl_core: streaming RGB to HSV and HSL converter
// Input channel carries one pixel per transaction; output carries
// hue (1/64 degree), both saturations (x65536), value and lightness.
// Stages: 1 front-end stage + 17 divider cells + output register.
// Throughput: one pixel per clock while the output is not stalled; the chain of
// division cells, one quotient bit per cell, is fully pipelined.
// The whole chain advances only while the output register can take data,
// so when the receiver stalls everything holds and in_ready_o drops;
// in_ready_o is high whenever the output slot is empty or being taken.
// Reset clears all valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_hsl_core import rhh_pkg::*; #(
  parameter int unsigned ColorBits = ColorBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ColorBits-1:0] red_i,
  input  logic [ColorBits-1:0] green_i,
  input  logic [ColorBits-1:0] blue_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [HueW-1:0]      hue_o,
  output logic [SatW-1:0]      hsv_saturation_o,
  output logic [ColorBits-1:0] brightness_o,
  output logic [SatW-1:0]      hsl_saturation_o,
  output logic [ColorBits:0]   lightness_o
);

  localparam int unsigned CB   = ColorBits;
  localparam int unsigned NumW = CB + 17;  // covers 6*3840*d and 65536*d
  localparam int unsigned QW   = SatW;
  localparam int unsigned NC   = QW;
  localparam logic [CB-1:0] Full = {CB{1'b1}};

  // Global enable: the chain is a rigid pipeline, stalled as a whole.
  logic adv;
  assign adv = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Front-end: max, min, numerators and the HSL denominator.
  logic [CB-1:0] mx, mn, d;
  logic [CB:0]   sum;
  sector_e       sect;
  logic [NumW-1:0] hnum, vnum, lnum;
  logic [CB-1:0]   lden;
  logic            hok;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i  > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i  < mn) mn = blue_i;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    if (mx == red_i) begin
      sect = (green_i >= blue_i) ? SECT_RED_POS : SECT_RED_NEG;
    end else if (mx == green_i) begin
      sect = SECT_GREEN;
    end else begin
      sect = SECT_BLUE;
    end
    case (sect)
      SECT_RED_POS: hnum = NumW'(HueUnit) * NumW'(green_i - blue_i);
      SECT_RED_NEG: hnum = NumW'(HueUnit) * (NumW'(6) * NumW'(d) - NumW'(blue_i - green_i));
      SECT_GREEN:   hnum = NumW'(HueUnit) * (NumW'(2) * NumW'(d) + NumW'(blue_i) - NumW'(red_i));
      SECT_BLUE:    hnum = NumW'(HueUnit) * (NumW'(4) * NumW'(d) + NumW'(red_i) - NumW'(green_i));
      default:      hnum = '0;
    endcase
    vnum = NumW'(d) << 16;
    lnum = NumW'(d) << 16;
    if (sum >= {1'b0, Full}) begin
      lden = CB'({1'b0, Full} - (sum - {1'b0, Full}));
    end else begin
      lden = CB'(sum);
    end
    hok = (mx != '0) && (mn != Full) && (lden != '0);
  end

  // Stage 0 registers
  logic            s0_vld_q;
  logic [NumW-1:0] s0_hn_q, s0_vn_q, s0_ln_q;
  logic [CB-1:0]   s0_hd_q, s0_vd_q, s0_ld_q, s0_mx_q;
  logic [CB:0]     s0_sum_q;
  logic            s0_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_hn_q  <= (d == '0) ? '0 : hnum;
      s0_hd_q  <= (d == '0) ? CB'(1) : d;
      s0_vn_q  <= (mx == '0) ? '0 : vnum;
      s0_vd_q  <= (mx == '0) ? CB'(1) : mx;
      s0_ln_q  <= hok ? lnum : '0;
      s0_ld_q  <= hok ? lden : CB'(1);
      s0_mx_q  <= mx;
      s0_sum_q <= sum;
      s0_ok_q  <= hok;
    end
  end

  // Cell chain: wires between cells
  logic            c_vld [NC+1];
  logic [NumW-1:0] c_hn [NC+1], c_vn [NC+1], c_ln [NC+1];
  logic [CB-1:0]   c_hd [NC+1], c_vd [NC+1], c_ld [NC+1], c_mx [NC+1];
  logic [QW-1:0]   c_hq [NC+1], c_vq [NC+1], c_lq [NC+1];
  logic [CB:0]     c_sum [NC+1];
  logic            c_ok [NC+1];

  assign c_vld[0] = s0_vld_q;
  assign c_hn[0]  = s0_hn_q;
  assign c_vn[0]  = s0_vn_q;
  assign c_ln[0]  = s0_ln_q;
  assign c_hd[0]  = s0_hd_q;
  assign c_vd[0]  = s0_vd_q;
  assign c_ld[0]  = s0_ld_q;
  assign c_mx[0]  = s0_mx_q;
  assign c_sum[0] = s0_sum_q;
  assign c_ok[0]  = s0_ok_q;
  assign c_hq[0]  = '0;
  assign c_vq[0]  = '0;
  assign c_lq[0]  = '0;

  // Each cell is wrapped by a hold mux.
  for (genvar k = 0; k < NC; k++) begin : g_cell
    logic            vld_w;
    logic [NumW-1:0] hn_w, vn_w, ln_w;
    logic [CB-1:0]   hd_w, vd_w, ld_w, mx_w;
    logic [QW-1:0]   hq_w, vq_w, lq_w;
    logic [CB:0]     sum_w;
    logic            ok_w;
    logic            vld_r;
    logic [NumW-1:0] hn_r, vn_r, ln_r;
    logic [CB-1:0]   hd_r, vd_r, ld_r, mx_r;
    logic [QW-1:0]   hq_r, vq_r, lq_r;
    logic [CB:0]     sum_r;
    logic            ok_r;

    // On stall, feed each cell its own output so it holds.
    assign vld_w = adv ? c_vld[k] : vld_r;
    assign hn_w  = adv ? c_hn[k]  : hn_r;
    assign vn_w  = adv ? c_vn[k]  : vn_r;
    assign ln_w  = adv ? c_ln[k]  : ln_r;
    assign hd_w  = adv ? c_hd[k]  : hd_r;
    assign vd_w  = adv ? c_vd[k]  : vd_r;
    assign ld_w  = adv ? c_ld[k]  : ld_r;
    assign mx_w  = adv ? c_mx[k]  : mx_r;
    assign hq_w  = adv ? c_hq[k]  : hq_r;
    assign vq_w  = adv ? c_vq[k]  : vq_r;
    assign lq_w  = adv ? c_lq[k]  : lq_r;
    assign sum_w = adv ? c_sum[k] : sum_r;
    assign ok_w  = adv ? c_ok[k]  : ok_r;

    // Hold path: the step reruns on its own remainder with the same divisor,
    // which is already below the shifted divisor, so nothing changes.
    logic [NumW-1:0] hn_h, vn_h, ln_h;
    logic [QW-1:0]   hq_h, vq_h, lq_h;
    always_comb begin
      hn_h = hn_w; vn_h = vn_w; ln_h = ln_w;
      hq_h = hq_w; vq_h = vq_w; lq_h = lq_w;
    end

    rhh_div_cell #(
      .CB(CB), .NumW(NumW), .QW(QW), .Shift(NC - 1 - k)
    ) u_cell (
      .clk_i (clk_i), .rst_ni (rst_ni),
      .vld_i (vld_w),
      .hn_i (adv ? hn_h : hn_r), .hd_i (hd_w), .hq_i (hq_h),
      .vn_i (adv ? vn_h : vn_r), .vd_i (vd_w), .vq_i (vq_h),
      .ln_i (adv ? ln_h : ln_r), .ld_i (ld_w), .lq_i (lq_h),
      .mx_i (mx_w), .sum_i (sum_w), .ok_i (ok_w),
      .vld_o (vld_r),
      .hn_o (hn_r), .hd_o (hd_r), .hq_o (hq_r),
      .vn_o (vn_r), .vd_o (vd_r), .vq_o (vq_r),
      .ln_o (ln_r), .ld_o (ld_r), .lq_o (lq_r),
      .mx_o (mx_r), .sum_o (sum_r), .ok_o (ok_r)
    );

    assign c_vld[k+1] = vld_r;
    assign c_hn[k+1]  = hn_r;
    assign c_vn[k+1]  = vn_r;
    assign c_ln[k+1]  = ln_r;
    assign c_hd[k+1]  = hd_r;
    assign c_vd[k+1]  = vd_r;
    assign c_ld[k+1]  = ld_r;
    assign c_mx[k+1]  = mx_r;
    assign c_hq[k+1]  = hq_r;
    assign c_vq[k+1]  = vq_r;
    assign c_lq[k+1]  = lq_r;
    assign c_sum[k+1] = sum_r;
    assign c_ok[k+1]  = ok_r;
  end

  // Output register
  logic            out_vld_q;
  logic [HueW-1:0] hue_q;
  logic [SatW-1:0] hsv_q, hsl_q;
  logic [CB-1:0]   br_q;
  logic [CB:0]     li_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= c_vld[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hue_q <= HueW'(c_hq[NC]);
      hsv_q <= c_vq[NC];
      hsl_q <= c_ok[NC] ? c_lq[NC] : '0;
      br_q  <= c_mx[NC];
      li_q  <= c_sum[NC];
    end
  end

  assign out_valid_o      = out_vld_q;
  assign hue_o            = hue_q;
  assign hsv_saturation_o = hsv_q;
  assign hsl_saturation_o = hsl_q;
  assign brightness_o     = br_q;
  assign lightness_o      = li_q;

endmodule
